### rtl/rcpd_pkg.sv
// Shared types and constants for the rank change-point detector.
// Used by every module of the block except rcpd_ram; depends on nothing else.
`timescale 1ns / 1ps

package rcpd_pkg;

  // Sample word width and window capacity.
  localparam int VALUE_BITS = 32;
  localparam int MAX_WINDOW = 256;
  localparam int ADDR_BITS  = $clog2(MAX_WINDOW);
  localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);

  // Statistic widths: rank sums and accumulated sums.
  localparam int SUM_BITS  = CNT_BITS + 1;
  localparam int ACC_BITS  = 16;
  localparam int STAT_BITS = 15;
  localparam int IDX_BITS  = 8;

  // Threshold register, unsigned Q8.16.
  localparam int                CFG_BITS  = 24;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 24'd241755;
  localparam int                FRAC_BITS = 16;

  // Widths of the test products.
  localparam int KSQ_BITS   = 2 * STAT_BITS;
  localparam int LHS_BITS   = KSQ_BITS + 3;
  localparam int NSQ_BITS   = 2 * CNT_BITS;
  localparam int NCUBE_BITS = 25;
  localparam int CMP_BITS   = CFG_BITS + NCUBE_BITS;

  // Input word.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         last;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [STAT_BITS-1:0] max_stat;
    logic [IDX_BITS-1:0]  change_index;
    logic                 significant;
    logic [CNT_BITS-1:0]  window_len;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic start;
    logic rd_i;
    logic lat_xi;
    logic sweep;
    logic acc;
    logic mul1;
    logic mul2;
    logic mul3;
    logic commit;
  } rcpd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic j_last;
    logic i_last;
  } rcpd_stat_t;

endpackage

### rtl/rcpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module rcpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rcpd_ctrl.sv
// Controller state machine: input and result handshakes and the evaluation sequence.
// Depends on rcpd_pkg for the command and status structs.
`timescale 1ns / 1ps

module rcpd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rcpd_pkg::rcpd_stat_t stat,
  output rcpd_pkg::rcpd_cmd_t  cmd
);
  import rcpd_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_RDI   = 4'd1;
  localparam logic [3:0] S_LATI  = 4'd2;
  localparam logic [3:0] S_SWEEP = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_MUL3  = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_ready  = (state_r == S_LOAD);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_LOAD: begin
        cmd.store = accept;
        if (accept && in_last) begin
          cmd.start = 1'b1;
          state_nxt = S_RDI;
        end
      end
      S_RDI: begin
        cmd.rd_i  = 1'b1;
        state_nxt = S_LATI;
      end
      S_LATI: begin
        cmd.lat_xi = 1'b1;
        state_nxt  = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.j_last) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = stat.i_last ? S_MUL1 : S_RDI;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // Wait until the output register is free, then load the result.
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/rcpd_datapath.sv
// Datapath: sample store, rank-sum sweep, running maximum and significance test.
// Depends on rcpd_pkg and instantiates rcpd_ram.
`timescale 1ns / 1ps

module rcpd_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [rcpd_pkg::CFG_BITS-1:0] cfg_data,
  input  rcpd_pkg::in_word_t        in_data,
  input  rcpd_pkg::rcpd_cmd_t       cmd,
  output rcpd_pkg::rcpd_stat_t      stat,
  output rcpd_pkg::out_word_t       out_data
);
  import rcpd_pkg::*;

  logic [CFG_BITS-1:0]          thresh_r;
  logic [CNT_BITS-1:0]          count_r;
  logic [CNT_BITS-1:0]          i_r;
  logic [CNT_BITS-1:0]          j_r;
  logic signed [VALUE_BITS-1:0] xi_r;
  logic signed [SUM_BITS-1:0]   s_r;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic [STAT_BITS-1:0]         best_r;
  logic [IDX_BITS-1:0]          best_idx_r;
  logic [KSQ_BITS-1:0]          ksq_r;
  logic [NSQ_BITS-1:0]          nsq_r;
  logic [LHS_BITS-1:0]          lhs_r;
  logic [NCUBE_BITS-1:0]        ncube_r;
  logic [CMP_BITS-1:0]          rhs_r;
  out_word_t                    out_r;

  logic                         full;
  logic                         ram_we;
  logic [ADDR_BITS-1:0]         raddr;
  logic [CNT_BITS-1:0]          j_inc;
  logic signed [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0]        rdata_raw;
  logic signed [SUM_BITS-1:0]   sgn;
  logic signed [ACC_BITS-1:0]   acc_sum;
  logic [ACC_BITS-1:0]          mag;
  logic [CNT_BITS:0]            n_plus1;
  logic [CMP_BITS-1:0]          lhs_full;
  logic [NSQ_BITS+CNT_BITS:0]   ncube_full;
  logic [CMP_BITS-1:0]          rhs_prod;

  assign full    = (count_r == CNT_BITS'(MAX_WINDOW));
  assign ram_we  = cmd.store && !full;
  assign j_inc   = j_r + 1'b1;
  assign raddr   = cmd.rd_i ? i_r[ADDR_BITS-1:0] :
                   (cmd.sweep ? j_inc[ADDR_BITS-1:0] : '0);
  assign rdata   = $signed(rdata_raw);

  assign stat.j_last = (j_r == count_r - 1'b1);
  assign stat.i_last = (i_r == count_r - 1'b1);

  // Sample store.
  rcpd_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[ADDR_BITS-1:0]),
    .wdata(in_data.sample_value),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  // Sign of the comparison of sample i against the word read back.
  always_comb begin
    if (xi_r > rdata) begin
      sgn = SUM_BITS'(1);
    end else if (xi_r < rdata) begin
      sgn = -SUM_BITS'(1);
    end else begin
      sgn = '0;
    end
  end

  // Accumulated sum and its magnitude.
  assign acc_sum = acc_r + ACC_BITS'(s_r);
  assign mag     = acc_sum[ACC_BITS-1] ? ACC_BITS'(-acc_sum) : ACC_BITS'(acc_sum);

  // Test operands.
  assign n_plus1    = {1'b0, count_r} + 1'b1;
  assign ncube_full = nsq_r * n_plus1;
  assign rhs_prod   = thresh_r * ncube_r;
  assign lhs_full   = {lhs_r, FRAC_BITS'(0)};

  // Control registers: threshold and sample count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= CFG_RESET;
      count_r  <= '0;
    end else begin
      if (cfg_valid) begin
        thresh_r <= cfg_data;
      end
      if (cmd.commit) begin
        count_r <= '0;
      end else if (ram_we) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Sweep counters, rank sum and running maximum.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i_r   <= '0;
      acc_r <= '0;
    end
    if (cmd.lat_xi) begin
      xi_r <= rdata;
      j_r  <= '0;
      s_r  <= '0;
    end
    if (cmd.sweep) begin
      s_r <= s_r + sgn;
      j_r <= j_inc;
    end
    if (cmd.acc) begin
      acc_r <= acc_sum;
      i_r   <= i_r + 1'b1;
      if (i_r == '0 || mag[STAT_BITS-1:0] > best_r) begin
        best_r     <= mag[STAT_BITS-1:0];
        best_idx_r <= i_r[IDX_BITS-1:0];
      end
    end
  end

  // Significance test: 6*K^2*2^16 >= L*N^2*(N+1), products formed in the mul1, mul2 and mul3 steps.
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      ksq_r <= best_r * best_r;
      nsq_r <= count_r * count_r;
    end
    if (cmd.mul2) begin
      lhs_r   <= LHS_BITS'(ksq_r) * LHS_BITS'(6);
      ncube_r <= ncube_full[NCUBE_BITS-1:0];
    end
    if (cmd.mul3) begin
      rhs_r <= rhs_prod;
    end
    if (cmd.commit) begin
      out_r.max_stat     <= best_r;
      out_r.change_index <= best_idx_r;
      out_r.significant  <= (lhs_full >= rhs_r);
      out_r.window_len   <= count_r;
    end
  end

  assign out_data = out_r;

endmodule

### rtl/rank_change_point_detector_unit.sv
// Sample words are taken at one per cycle, but only while loading. After the word marked
// last, the window is evaluated and its result appears once the output register is free.
// Evaluation speed is set by the single read port of the sample store, which is read once
// per comparison. Words are taken only while loading, so no new window enters meanwhile.
// Reset (rst_n low, synchronous) empties the window, drops any pending result and
// restores the threshold register; the sample store is not cleared.
`timescale 1ns / 1ps

module rank_change_point_detector_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcpd_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rcpd_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rcpd_pkg::out_word_t           out_data
);
  import rcpd_pkg::*;

  rcpd_cmd_t  cmd;
  rcpd_stat_t stat;

  // The threshold register accepts a word in every cycle.
  assign cfg_ready = 1'b1;

  // Sequencer.
  rcpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  rcpd_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

### rtl/rcpd_checker.sv
// Port-level checks for the rank change-point detector, bound to the top level.
// Depends on rcpd_pkg for the word types.
`timescale 1ns / 1ps

module rcpd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input rcpd_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rcpd_pkg::out_word_t out_data
);
  import rcpd_pkg::*;

  // A pending result word holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A closed window stops input: in_ready drops after the word marked last is taken.
  a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last |=> !in_ready)
    else $error("input taken during evaluation");

  // Window length is nonzero and lies within the store capacity.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.window_len != '0 &&
                  out_data.window_len <= CNT_BITS'(MAX_WINDOW))
    else $error("window length out of range");

  // The change index points into the window.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> CNT_BITS'(out_data.change_index) < out_data.window_len)
    else $error("change index outside window");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind rank_change_point_detector_unit rcpd_checker u_rcpd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

### tb/sv/rank_change_point_detector_unit_tb.sv
// Self-checking testbench for the rank change-point detector unit.
// Depends on rcpd_pkg and rank_change_point_detector_unit; predicts every window result
// in a small scoreboard class; out_ready is driven from a loop, in and cfg from tasks.
`timescale 1ns / 1ps

module rank_change_point_detector_unit_tb;
  import rcpd_pkg::*;

  localparam int LIMIT_CYCLES = 600_000;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 32;
  localparam int MIN_WINDOWS  = 48;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 8;

  // Value patterns for a window of samples.
  typedef enum int {SHAPE_WIDE, SHAPE_TIES, SHAPE_RAMP, SHAPE_SHIFT} shape_t;

  // Scoreboard: holds its own copy of the window and threshold, and a queue of the
  // statistics that closed windows must produce.
  class window_scoreboard;
    logic signed [VALUE_BITS-1:0] held [MAX_WINDOW];
    int unsigned                  held_count;
    logic [CFG_BITS-1:0]          threshold;
    out_word_t                    pending_stats [$];
    int                           errors;

    function new();
      held_count = 0;
      threshold  = CFG_RESET;
      errors     = 0;
    endfunction

    function void set_threshold(logic [CFG_BITS-1:0] value);
      threshold = value;
    endfunction

    // Pettitt statistic over the held window: K, first index of K, and the test.
    function out_word_t window_statistic();
      out_word_t         r;
      longint            acc, mag, best, rank_sum;
      int unsigned       best_at;
      longint unsigned   lhs, rhs, n;
      acc     = 0;
      best    = 0;
      best_at = 0;
      for (int i = 0; i < held_count; i++) begin
        rank_sum = 0;
        for (int j = 0; j < held_count; j++) begin
          if (held[i] > held[j]) rank_sum++;
          else if (held[i] < held[j]) rank_sum--;
        end
        acc += rank_sum;
        mag = (acc < 0) ? -acc : acc;
        // Only a strictly larger magnitude moves the change index.
        if (i == 0 || mag > best) begin
          best    = mag;
          best_at = i;
        end
      end
      n   = held_count;
      lhs = best * best * 6 * 65536;
      rhs = longint'(threshold) * n * n * (n + 1);
      r.max_stat     = best[STAT_BITS-1:0];
      r.change_index = best_at[IDX_BITS-1:0];
      r.significant  = (lhs >= rhs);
      r.window_len   = held_count[CNT_BITS-1:0];
      return r;
    endfunction

    // A full store drops the word, but its last flag still closes the window.
    function void note_word(in_word_t w);
      if (held_count < MAX_WINDOW) begin
        held[held_count] = w.sample_value;
        held_count++;
      end
      if (w.last) begin
        pending_stats = {pending_stats, window_statistic()};
        held_count = 0;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %p", $time, got);
        errors++;
        return;
      end
      want = pending_stats[0];
      pending_stats.delete(0);
      if (got.max_stat !== want.max_stat) begin
        $display("%0t: max_stat expected %0d, got %0d", $time, want.max_stat, got.max_stat);
        errors++;
      end
      if (got.change_index !== want.change_index) begin
        $display("%0t: change_index expected %0d, got %0d", $time,
                 want.change_index, got.change_index);
        errors++;
      end
      if (got.significant !== want.significant) begin
        $display("%0t: significant expected %0b, got %0b", $time,
                 want.significant, got.significant);
        errors++;
      end
      if (got.window_len !== want.window_len) begin
        $display("%0t: window_len expected %0d, got %0d", $time,
                 want.window_len, got.window_len);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_data;

  window_scoreboard board;
  int               cycle_count;
  int               words_sent;
  int               windows_sent;
  bit               sender_idle_on;
  bit               receiver_idle_on;
  bit               hold_request;

  rank_change_point_detector_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("rank_change_point_detector_unit_tb failed");
      $finish;
    end
  end

  // Observe every handshake at the edge where it completes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_threshold(cfg_data);
      if (in_valid && in_ready) board.note_word(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
    end
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one sample word and hold it until it is taken.
  task automatic send_word(input logic signed [VALUE_BITS-1:0] value, input logic last);
    int gap;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample_value: value, last: last};
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Send one window of len samples shaped by the given pattern.
  task automatic send_window(input int len, input shape_t shape);
    logic signed [VALUE_BITS-1:0] value;
    int                           offset, stride, split;
    offset = $urandom_range(0, 1000);
    stride = $urandom_range(1, 1000) * ($urandom_range(0, 1) ? 1 : -1);
    split  = $urandom_range(0, len);
    for (int k = 0; k < len; k++) begin
      case (shape)
        SHAPE_WIDE:  value = $urandom;
        SHAPE_TIES:  value = $urandom_range(0, 4) - 2;
        SHAPE_RAMP:  value = offset + k * stride;
        default:     value = (k < split ? 0 : 1000) + $urandom_range(0, 300);
      endcase
      send_word(value, k == len - 1);
    end
    windows_sent++;
  endtask

  // Stop offering and wait until every expected result has come out.
  // The first wait lets the scoreboard see the word taken at the current edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Threshold writes happen only with the block idle.
  task automatic write_threshold(input logic [CFG_BITS-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int              start_words;
    int              len;
    logic [CFG_BITS-1:0] level;
    board            = new();
    cycle_count      = 0;
    words_sent       = 0;
    windows_sent     = 0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    hold_request     = 1'b0;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed windows under the reset threshold.
    // A single sample gives K of zero at index zero.
    send_word(32'sh7FFF_FFFF, 1'b1);
    // Extremes of the sample range.
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh0000_0000, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd1, 1'b1);
    // All samples equal: every rank sum is zero.
    repeat (3) send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b1);
    // The maximum magnitude occurs twice; the first index must win.
    send_word(32'sd0, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(32'sd2, 1'b1);
    // Falling series.
    send_word(32'sd40, 1'b0);
    send_word(32'sd30, 1'b0);
    send_word(32'sd20, 1'b0);
    send_word(32'sd10, 1'b1);

    // Random windows, one threshold setting per phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       level = '0;
        1:       level = {CFG_BITS{1'b1}};
        2:       level = CFG_RESET;
        default: level = CFG_BITS'(($urandom_range(0, 3) == 0) ? $urandom :
                                   $urandom_range(0, 24'h7_FFFF));
      endcase
      write_threshold(level);
      if (phase == PHASES - 1) begin
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
      end
      // Long receiver hold while windows keep coming.
      if (phase == 1) hold_request = 1'b1;
      // Overfull ramp window: extra words are dropped and K reaches its top value.
      if (phase == 3) send_window(MAX_WINDOW + $urandom_range(1, 3), SHAPE_RAMP);
      start_words = words_sent;
      while (words_sent - start_words < PHASE_WORDS ||
             (phase == PHASES - 1 && windows_sent < MIN_WINDOWS)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        send_window(len, shape_t'($urandom_range(0, 3)));
      end
    end

    drain();
    repeat (64) @(posedge clk);
    if (board.errors == 0 && board.pending_stats.size() == 0) begin
      $display("rank_change_point_detector_unit_tb passed");
    end else begin
      $display("rank_change_point_detector_unit_tb failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rcpd_pkg.sv
rtl/rcpd_ram.sv
rtl/rcpd_ctrl.sv
rtl/rcpd_datapath.sv
rtl/rank_change_point_detector_unit.sv
rtl/rcpd_checker.sv
tb/sv/rank_change_point_detector_unit_tb.sv
